>>> rtl/vcpu_load_rebalancer_core_macros.svh
// assertion macros for the vcpu load rebalancer
`ifndef VCPU_LOAD_REBALANCER_CORE_MACROS_SVH
`define VCPU_LOAD_REBALANCER_CORE_MACROS_SVH

// same-cycle implication
`define VLR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define VLR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/vlr_pkg.sv
// shared constants and controller/datapath types for the vcpu load rebalancer
package vlr_pkg;

    localparam int MAX_VMS_DEF   = 32;
    localparam int MAX_PCPUS_DEF = 32;

    localparam int CNT_W   = 7;
    localparam int P_W     = 7;
    localparam int LOAD_W  = 20;
    localparam int USAGE_W = 15;
    localparam int HOME_W  = 5;
    localparam int THR_W   = 15;
    localparam int SUM_W   = 27;
    localparam int SQ_W    = 47;
    localparam int LHS_W   = 54;
    localparam int CFG_A_W = 1;
    localparam int CFG_D_W = 15;

    localparam logic [LOAD_W-1:0] LOAD_MAX = '1;

    localparam logic [CFG_A_W-1:0] CFG_NUM_PCPUS = 1'd0;
    localparam logic [CFG_A_W-1:0] CFG_THRESHOLD = 1'd1;

    localparam logic [5:0]      NUM_PCPUS_RST = 6'd8;
    localparam logic [THR_W-1:0] THRESHOLD_RST = 15'd1280;

    typedef struct packed {
        logic             wr_item;
        logic [CNT_W-1:0] wr_addr;
        logic             ld_clr;
        logic             load_clr;
        logic             rd_a;
        logic             a_sel_vm;
        logic [CNT_W-1:0] a_addr;
        logic             rd_b;
        logic [CNT_W-1:0] b_addr;
        logic             acc_issue;
        logic             var_clr;
        logic             var_issue;
        logic [CNT_W-1:0] cpu_idx;
        logic             mul1;
        logic             mul2;
        logic             rank_issue;
        logic             ord_wr;
        logic             ord_rd;
        logic [CNT_W-1:0] rank_i;
        logic             pl_first;
        logic             min_init;
        logic             min_step;
        logic             pl_add;
        logic             res_ld;
        logic             res_bal;
        logic             res_last;
    } t_dp_cmd;

    typedef struct packed {
        logic unb;
        logic res_last;
    } t_dp_sts;

endpackage

>>> rtl/vlr_datapath.sv
// item stores, cpu loads, variance arithmetic, ranking and placement datapath
module vlr_datapath #(
    parameter int MAX_VMS   = vlr_pkg::MAX_VMS_DEF,
    parameter int MAX_PCPUS = vlr_pkg::MAX_PCPUS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  vlr_pkg::t_dp_cmd            i_cmd,
    output vlr_pkg::t_dp_sts            o_sts,
    input  logic [vlr_pkg::P_W-1:0]     i_p,
    input  logic [vlr_pkg::THR_W-1:0]   i_thr,
    input  logic [vlr_pkg::USAGE_W-1:0] i_usage,
    input  logic [vlr_pkg::HOME_W-1:0]  i_home,
    output logic                        o_unbalanced,
    output logic [4:0]                  o_vm_index,
    output logic [4:0]                  o_target_pcpu,
    output logic                        o_moved,
    output logic                        o_last_result
);
    localparam int VA_W = $clog2(MAX_VMS);
    localparam int PA_W = $clog2(MAX_PCPUS);

    logic [vlr_pkg::USAGE_W-1:0] r_usage_mem [MAX_VMS];
    logic [vlr_pkg::HOME_W-1:0]  r_home_mem  [MAX_VMS];
    logic [VA_W-1:0]             r_ord_mem   [MAX_VMS];

    logic [vlr_pkg::LOAD_W-1:0]  r_load [MAX_PCPUS];
    logic [MAX_PCPUS-1:0]        r_taken;

    logic [vlr_pkg::USAGE_W-1:0] r_ua, r_ub;
    logic [vlr_pkg::HOME_W-1:0]  r_ha;
    logic [VA_W-1:0]             r_id, r_jd, r_vm;
    logic                        r_acc_v, r_sq_v, r_rk_v;
    logic [vlr_pkg::CNT_W-1:0]   r_rank;
    logic [PA_W-1:0]             r_tgt;
    logic [vlr_pkg::LOAD_W-1:0]  r_min;

    logic [2*vlr_pkg::LOAD_W-1:0] r_sq;
    logic [vlr_pkg::SUM_W-1:0]    r_sum;
    logic [vlr_pkg::SQ_W-1:0]     r_sumsq;
    logic [vlr_pkg::LHS_W-1:0]    r_a, r_b, r_lhs;
    logic [2*vlr_pkg::THR_W-1:0]  r_t2;
    logic [2*vlr_pkg::P_W-1:0]    r_p2;
    logic [2*vlr_pkg::THR_W+2*vlr_pkg::P_W-1:0] r_rhs;

    logic [VA_W-1:0]            a_addr;
    logic [PA_W-1:0]            hc, ld_ra, first_free, tgt_first;
    logic [vlr_pkg::LOAD_W-1:0] rd_load, sat_sum;
    logic [vlr_pkg::LOAD_W:0]   raw_sum;
    logic                       greater;

    assign a_addr = i_cmd.a_sel_vm ? r_vm : i_cmd.a_addr[VA_W-1:0];

    // home cpu folded into range
    always_comb begin
        if ({2'b00, r_ha} >= i_p) begin
            hc = PA_W'(i_p - vlr_pkg::P_W'(1));
        end else begin
            hc = PA_W'(r_ha);
        end
    end

    always_comb begin
        if (r_acc_v) begin
            ld_ra = hc;
        end else if (i_cmd.var_issue || i_cmd.min_step) begin
            ld_ra = i_cmd.cpu_idx[PA_W-1:0];
        end else if (i_cmd.pl_add) begin
            ld_ra = r_tgt;
        end else begin
            ld_ra = '0;
        end
    end

    assign rd_load = r_load[ld_ra];
    assign raw_sum = {1'b0, rd_load} + (vlr_pkg::LOAD_W+1)'(r_ua);
    assign sat_sum = raw_sum[vlr_pkg::LOAD_W] ? vlr_pkg::LOAD_MAX : raw_sum[vlr_pkg::LOAD_W-1:0];

    // lowest free cpu below the active count
    always_comb begin
        first_free = '0;
        for (int k = MAX_PCPUS - 1; k >= 0; k--) begin
            if (!r_taken[k] && (vlr_pkg::P_W'(k) < i_p)) begin
                first_free = PA_W'(k);
            end
        end
    end

    assign tgt_first = r_taken[hc] ? first_free : hc;
    assign greater   = (r_ub > r_ua) || ((r_ub == r_ua) && (r_jd < r_id));

    // memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_item) begin
            r_usage_mem[i_cmd.wr_addr[VA_W-1:0]] <= i_usage;
            r_home_mem[i_cmd.wr_addr[VA_W-1:0]]  <= i_home;
        end
        if (i_cmd.rd_a) begin
            r_ua <= r_usage_mem[a_addr];
            r_ha <= r_home_mem[a_addr];
        end
        if (i_cmd.rd_b) begin
            r_ub <= r_usage_mem[i_cmd.b_addr[VA_W-1:0]];
        end
        if (i_cmd.ord_wr) begin
            r_ord_mem[r_rank[VA_W-1:0]] <= i_cmd.rank_i[VA_W-1:0];
        end
        if (i_cmd.ord_rd) begin
            r_vm <= r_ord_mem[i_cmd.rank_i[VA_W-1:0]];
        end
    end

    // loads and taken flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.ld_clr) begin
            for (int k = 0; k < MAX_PCPUS; k++) begin
                r_load[k] <= '0;
            end
            r_taken <= '0;
        end else if (i_cmd.load_clr) begin
            for (int k = 0; k < MAX_PCPUS; k++) begin
                r_load[k] <= '0;
            end
        end else if (r_acc_v) begin
            r_load[hc] <= sat_sum;
        end else if (i_cmd.pl_first) begin
            r_load[tgt_first]  <= vlr_pkg::LOAD_W'(r_ua);
            r_taken[tgt_first] <= 1'b1;
        end else if (i_cmd.pl_add) begin
            r_load[r_tgt] <= sat_sum;
        end
    end

    // pipeline valids and rank counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_v <= 1'b0;
            r_sq_v  <= 1'b0;
            r_rk_v  <= 1'b0;
            r_rank  <= '0;
        end else begin
            r_acc_v <= i_cmd.acc_issue;
            r_sq_v  <= i_cmd.var_issue;
            r_rk_v  <= i_cmd.rank_issue;
            if (i_cmd.ld_clr || i_cmd.ord_wr) begin
                r_rank <= '0;
            end else if (r_rk_v && greater) begin
                r_rank <= r_rank + vlr_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rank_issue) begin
            r_id <= i_cmd.rank_i[VA_W-1:0];
            r_jd <= i_cmd.b_addr[VA_W-1:0];
        end
        if (i_cmd.pl_first) begin
            r_tgt <= tgt_first;
        end else if (i_cmd.min_init) begin
            r_tgt <= '0;
            r_min <= rd_load;
        end else if (i_cmd.min_step && (rd_load < r_min)) begin
            r_tgt <= i_cmd.cpu_idx[PA_W-1:0];
            r_min <= rd_load;
        end
    end

    // variance terms: p*sum(l^2) - (sum l)^2 against t^2*p^2
    always_ff @(posedge i_clk) begin
        if (i_cmd.var_clr) begin
            r_sum   <= '0;
            r_sumsq <= '0;
        end else begin
            if (i_cmd.var_issue) begin
                r_sq  <= rd_load * rd_load;
                r_sum <= r_sum + vlr_pkg::SUM_W'(rd_load);
            end
            if (r_sq_v) begin
                r_sumsq <= r_sumsq + vlr_pkg::SQ_W'(r_sq);
            end
        end
        if (i_cmd.mul1) begin
            r_a  <= vlr_pkg::LHS_W'(i_p) * vlr_pkg::LHS_W'(r_sumsq);
            r_b  <= vlr_pkg::LHS_W'(r_sum) * vlr_pkg::LHS_W'(r_sum);
            r_t2 <= i_thr * i_thr;
            r_p2 <= i_p * i_p;
        end
        if (i_cmd.mul2) begin
            r_lhs <= r_a - r_b;
            r_rhs <= r_t2 * r_p2;
        end
    end

    assign o_sts.unb      = r_lhs > vlr_pkg::LHS_W'(r_rhs);
    assign o_sts.res_last = o_last_result;

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_ld) begin
            if (i_cmd.res_bal) begin
                o_unbalanced  <= 1'b0;
                o_vm_index    <= '0;
                o_target_pcpu <= '0;
                o_moved       <= 1'b0;
                o_last_result <= 1'b1;
            end else begin
                o_unbalanced  <= 1'b1;
                o_vm_index    <= 5'(r_vm);
                o_target_pcpu <= 5'(r_tgt);
                o_moved       <= r_tgt != hc;
                o_last_result <= i_cmd.res_last;
            end
        end
    end

endmodule

>>> rtl/vlr_controller.sv
// batch sequencer: collect, load sum, variance test, rank sort, placement, result
module vlr_controller #(
    parameter int MAX_VMS = vlr_pkg::MAX_VMS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_last_vm,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    input  logic [vlr_pkg::P_W-1:0] i_p,
    output vlr_pkg::t_dp_cmd        o_cmd,
    input  vlr_pkg::t_dp_sts        i_sts
);
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_LCLR = 5'd1;
    localparam logic [4:0] S_LACC = 5'd2;
    localparam logic [4:0] S_LDRN = 5'd3;
    localparam logic [4:0] S_VAR  = 5'd4;
    localparam logic [4:0] S_VDRN = 5'd5;
    localparam logic [4:0] S_M1   = 5'd6;
    localparam logic [4:0] S_M2   = 5'd7;
    localparam logic [4:0] S_M3   = 5'd8;
    localparam logic [4:0] S_SJ   = 5'd9;
    localparam logic [4:0] S_SD   = 5'd10;
    localparam logic [4:0] S_SW   = 5'd11;
    localparam logic [4:0] S_PO   = 5'd12;
    localparam logic [4:0] S_PU   = 5'd13;
    localparam logic [4:0] S_PD   = 5'd14;
    localparam logic [4:0] S_PM   = 5'd15;
    localparam logic [4:0] S_PA   = 5'd16;
    localparam logic [4:0] S_PR   = 5'd17;
    localparam logic [4:0] S_OUT  = 5'd18;

    localparam logic [vlr_pkg::CNT_W-1:0] CNT_MAX = vlr_pkg::CNT_W'(MAX_VMS);
    localparam logic [vlr_pkg::CNT_W-1:0] ONE     = vlr_pkg::CNT_W'(1);

    logic [4:0]                r_state, n_state;
    logic [vlr_pkg::CNT_W-1:0] r_cnt, n_cnt, r_i, n_i, r_j, n_j;
    logic [vlr_pkg::CNT_W-1:0] n_last, p_last;
    logic                      in_acc;

    assign n_last = r_cnt - ONE;
    assign p_last = vlr_pkg::CNT_W'(i_p) - ONE;
    assign in_acc = i_in_valid && o_in_ready;

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_state == S_OUT;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_i     = r_i;
        n_j     = r_j;
        o_cmd   = '0;
        o_cmd.wr_addr = r_cnt;
        o_cmd.a_addr  = r_i;
        o_cmd.b_addr  = r_j;
        o_cmd.cpu_idx = r_j;
        o_cmd.rank_i  = r_i;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (r_cnt < CNT_MAX) begin
                        o_cmd.wr_item = 1'b1;
                        n_cnt = r_cnt + ONE;
                    end
                    if (i_last_vm) begin
                        n_state = S_LCLR;
                    end
                end
            end
            S_LCLR: begin
                o_cmd.ld_clr  = 1'b1;
                o_cmd.var_clr = 1'b1;
                n_i = '0;
                n_state = S_LACC;
            end
            S_LACC: begin
                o_cmd.rd_a      = 1'b1;
                o_cmd.acc_issue = 1'b1;
                if (r_i == n_last) begin
                    n_state = S_LDRN;
                end else begin
                    n_i = r_i + ONE;
                end
            end
            S_LDRN: begin
                n_j = '0;
                n_state = S_VAR;
            end
            S_VAR: begin
                o_cmd.var_issue = 1'b1;
                if (r_j == p_last) begin
                    n_state = S_VDRN;
                end else begin
                    n_j = r_j + ONE;
                end
            end
            S_VDRN: begin
                n_state = S_M1;
            end
            S_M1: begin
                o_cmd.mul1     = 1'b1;
                o_cmd.load_clr = 1'b1;
                n_state = S_M2;
            end
            S_M2: begin
                o_cmd.mul2 = 1'b1;
                n_state = S_M3;
            end
            S_M3: begin
                n_i = '0;
                n_j = '0;
                if (i_sts.unb) begin
                    n_state = S_SJ;
                end else begin
                    o_cmd.res_ld  = 1'b1;
                    o_cmd.res_bal = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_SJ: begin
                o_cmd.rd_a       = 1'b1;
                o_cmd.rd_b       = 1'b1;
                o_cmd.rank_issue = 1'b1;
                if (r_j == n_last) begin
                    n_state = S_SD;
                end else begin
                    n_j = r_j + ONE;
                end
            end
            S_SD: begin
                n_state = S_SW;
            end
            S_SW: begin
                o_cmd.ord_wr = 1'b1;
                n_j = '0;
                if (r_i == n_last) begin
                    n_i = '0;
                    n_state = S_PO;
                end else begin
                    n_i = r_i + ONE;
                    n_state = S_SJ;
                end
            end
            S_PO: begin
                o_cmd.ord_rd = 1'b1;
                n_state = S_PU;
            end
            S_PU: begin
                o_cmd.rd_a     = 1'b1;
                o_cmd.a_sel_vm = 1'b1;
                n_state = S_PD;
            end
            S_PD: begin
                // first p vms take a cpu of their own
                if (r_i < vlr_pkg::CNT_W'(i_p)) begin
                    o_cmd.pl_first = 1'b1;
                    n_state = S_PR;
                end else begin
                    o_cmd.min_init = 1'b1;
                    n_j = ONE;
                    n_state = S_PM;
                end
            end
            S_PM: begin
                if (r_j < vlr_pkg::CNT_W'(i_p)) begin
                    o_cmd.min_step = 1'b1;
                    n_j = r_j + ONE;
                end else begin
                    n_state = S_PA;
                end
            end
            S_PA: begin
                o_cmd.pl_add = 1'b1;
                n_state = S_PR;
            end
            S_PR: begin
                o_cmd.res_ld   = 1'b1;
                o_cmd.res_last = r_i == n_last;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    if (i_sts.res_last) begin
                        n_cnt = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_i = r_i + ONE;
                        n_state = S_PO;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_i     <= n_i;
            r_j     <= n_j;
        end
    end

endmodule

>>> rtl/vcpu_load_rebalancer_core.sv
// an item that is not last is taken while idle; the last item starts the batch run
// batch run: sum and test the loads, then rank-sort the vms by usage
// placement: the first p vms take a cpu of their own, each later vm the least-loaded cpu
// the rank sort compares one pair of usages per cycle within a row; results wait for ready
// synchronous active-low reset: idle, empty batch, num_pcpus 8, threshold 1280
module vcpu_load_rebalancer_core #(
    parameter int MAX_VMS   = vlr_pkg::MAX_VMS_DEF,
    parameter int MAX_PCPUS = vlr_pkg::MAX_PCPUS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [vlr_pkg::CFG_A_W-1:0]   i_cfg_index,
    input  logic [vlr_pkg::CFG_D_W-1:0]   i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [14:0]                   i_vm_usage,
    input  logic [4:0]                    i_current_pcpu,
    input  logic                          i_last_vm,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_unbalanced,
    output logic [4:0]                    o_vm_index,
    output logic [4:0]                    o_target_pcpu,
    output logic                          o_moved,
    output logic                          o_last_result
);
    localparam logic [vlr_pkg::P_W-1:0] P_MAX = vlr_pkg::P_W'(MAX_PCPUS);

    logic [5:0]                r_num_pcpus;
    logic [vlr_pkg::THR_W-1:0] r_thr;
    logic [vlr_pkg::P_W-1:0]   p_eff;
    vlr_pkg::t_dp_cmd          cmd;
    vlr_pkg::t_dp_sts          sts;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_pcpus <= vlr_pkg::NUM_PCPUS_RST;
            r_thr       <= vlr_pkg::THRESHOLD_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                vlr_pkg::CFG_NUM_PCPUS: r_num_pcpus <= i_cfg_data[5:0];
                vlr_pkg::CFG_THRESHOLD: r_thr       <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // zero acts as one cpu, oversize as the maximum
    always_comb begin
        if (r_num_pcpus == '0) begin
            p_eff = vlr_pkg::P_W'(1);
        end else if ({1'b0, r_num_pcpus} > P_MAX) begin
            p_eff = P_MAX;
        end else begin
            p_eff = {1'b0, r_num_pcpus};
        end
    end

    vlr_controller #(
        .MAX_VMS (MAX_VMS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_last_vm   (i_last_vm),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_p         (p_eff),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    vlr_datapath #(
        .MAX_VMS   (MAX_VMS),
        .MAX_PCPUS (MAX_PCPUS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_p           (p_eff),
        .i_thr         (r_thr),
        .i_usage       (i_vm_usage),
        .i_home        (i_current_pcpu),
        .o_unbalanced  (o_unbalanced),
        .o_vm_index    (o_vm_index),
        .o_target_pcpu (o_target_pcpu),
        .o_moved       (o_moved),
        .o_last_result (o_last_result)
    );

`include "vcpu_load_rebalancer_core_macros.svh"

    `VLR_ASSERT_IMP(a_no_overlap, i_clk, i_rst_n, o_out_valid, !o_in_ready, "input taken during result phase")
    `VLR_ASSERT_NXT(a_idle_after_last, i_clk, i_rst_n, o_out_valid && i_out_ready && o_last_result, o_in_ready, "not idle after last result")
    `VLR_ASSERT_IMP(a_balanced_shape, i_clk, i_rst_n, o_out_valid && !o_unbalanced, o_last_result && !o_moved && o_vm_index == 5'd0 && o_target_pcpu == 5'd0, "malformed balanced result")

endmodule

>>> tb/vcpu_load_rebalancer_core_test.sv
// self-checking testbench for the vcpu load rebalancer core
module vcpu_load_rebalancer_core_test;

    localparam int VM_SLOTS   = 32;
    localparam int IDLE_LIMIT = 20000;

    typedef struct {
        bit       unbalanced;
        bit [4:0] vm_index;
        bit [4:0] target_pcpu;
        bit       moved;
        bit       last_result;
    } t_placement;

    // tracks the batch being loaded and the placements still owed by the block
    class placement_board;
        bit [5:0]      pcpus_reg;
        bit [14:0]     threshold_reg;
        bit [14:0]     usage_mem[VM_SLOTS];
        bit [4:0]      home_mem[VM_SLOTS];
        int            vm_cnt;
        t_placement    awaited[$];
        int            errors;
        int            results_seen;
        int            batches;
        int            unbalanced_batches;

        function new();
            pcpus_reg = vlr_pkg::NUM_PCPUS_RST;
            threshold_reg = vlr_pkg::THRESHOLD_RST;
            vm_cnt = 0;
            errors = 0;
            results_seen = 0;
            batches = 0;
            unbalanced_batches = 0;
        endfunction

        function void report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endfunction

        function bit [19:0] add_sat(bit [19:0] a, bit [19:0] b);
            int unsigned s;
            s = a + b;
            return (s > 1048575) ? 20'hfffff : s[19:0];
        endfunction

        function void note_vm(bit [14:0] usage, bit [4:0] cpu, bit last);
            if (vm_cnt < VM_SLOTS) begin
                usage_mem[vm_cnt] = usage;
                home_mem[vm_cnt] = cpu;
                vm_cnt++;
            end
            if (last)
                place_batch();
        endfunction

        // greedy placement, largest usage first
        function void place_batch();
            int p, n, i, j, first, tgt, vm, home, v;
            bit [19:0] load[VM_SLOTS];
            bit taken[VM_SLOTS];
            int order[VM_SLOTS];
            longint unsigned sum, sumsq, lhs, rhs;
            t_placement r;
            p = (pcpus_reg == 0) ? 1 : ((pcpus_reg > 32) ? 32 : int'(pcpus_reg));
            n = vm_cnt;
            batches++;
            for (i = 0; i < VM_SLOTS; i++) begin
                load[i] = 0;
                taken[i] = 0;
                order[i] = 0;
            end
            for (i = 0; i < n; i++) begin
                if (home_mem[i] >= p)
                    home_mem[i] = p - 1;
                load[home_mem[i]] = add_sat(load[home_mem[i]], usage_mem[i]);
            end
            sum = 0;
            sumsq = 0;
            for (i = 0; i < p; i++) begin
                sum += load[i];
                sumsq += longint'(load[i]) * longint'(load[i]);
            end
            lhs = longint'(p) * sumsq - sum * sum;
            rhs = longint'(threshold_reg) * longint'(threshold_reg) * longint'(p) * longint'(p);
            if (lhs <= rhs) begin
                r = '{0, 0, 0, 0, 1};
                awaited.push_back(r);
            end else begin
                unbalanced_batches++;
                // stable descending sort, earlier arrival wins ties
                for (i = 0; i < n; i++) begin
                    v = i;
                    j = i;
                    while (j > 0 && usage_mem[order[j-1]] < usage_mem[v]) begin
                        order[j] = order[j-1];
                        j--;
                    end
                    order[j] = v;
                end
                for (i = 0; i < VM_SLOTS; i++)
                    load[i] = 0;
                first = (n < p) ? n : p;
                for (i = 0; i < n; i++) begin
                    vm = order[i];
                    home = home_mem[vm];
                    tgt = 0;
                    if (i < first) begin
                        if (!taken[home]) begin
                            tgt = home;
                        end else begin
                            for (j = p - 1; j >= 0; j--)
                                if (!taken[j]) tgt = j;
                        end
                        taken[tgt] = 1;
                        load[tgt] = usage_mem[vm];
                    end else begin
                        for (j = 1; j < p; j++)
                            if (load[j] < load[tgt]) tgt = j;
                        load[tgt] = add_sat(load[tgt], usage_mem[vm]);
                    end
                    r = '{1, vm[4:0], tgt[4:0], tgt != home, i + 1 == n};
                    awaited.push_back(r);
                end
            end
            vm_cnt = 0;
        endfunction

        function void check_result(t_placement got);
            t_placement want;
            results_seen++;
            if (awaited.size() == 0) begin
                report($sformatf("unexpected result vm %0d cpu %0d", got.vm_index,
                                 got.target_pcpu));
                return;
            end
            want = awaited.pop_front();
            if (got.unbalanced != want.unbalanced)
                report($sformatf("unbalanced %0d, want %0d", got.unbalanced, want.unbalanced));
            if (got.vm_index != want.vm_index)
                report($sformatf("vm_index %0d, want %0d", got.vm_index, want.vm_index));
            if (got.target_pcpu != want.target_pcpu)
                report($sformatf("target_pcpu %0d, want %0d (vm %0d)", got.target_pcpu,
                                 want.target_pcpu, want.vm_index));
            if (got.moved != want.moved)
                report($sformatf("moved %0d, want %0d (vm %0d)", got.moved, want.moved,
                                 want.vm_index));
            if (got.last_result != want.last_result)
                report($sformatf("last_result %0d, want %0d", got.last_result,
                                 want.last_result));
        endfunction
    endclass

    logic                         i_clk = 0;
    logic                         i_rst_n = 0;
    logic                         i_cfg_valid = 0;
    logic                         o_cfg_ready;
    logic [vlr_pkg::CFG_A_W-1:0]  i_cfg_index = vlr_pkg::CFG_NUM_PCPUS;
    logic [vlr_pkg::CFG_D_W-1:0]  i_cfg_data = 0;
    logic                         i_in_valid = 0;
    logic                         o_in_ready;
    logic [14:0]                  i_vm_usage = 0;
    logic [4:0]                   i_current_pcpu = 0;
    logic                         i_last_vm = 0;
    logic                         o_out_valid;
    logic                         i_out_ready = 0;
    logic                         o_unbalanced;
    logic [4:0]                   o_vm_index;
    logic [4:0]                   o_target_pcpu;
    logic                         o_moved;
    logic                         o_last_result;

    placement_board board = new();
    int  items_sent = 0;
    int  idle_cycles = 0;
    bit  hold_request = 0;
    bit  hold_done = 0;

    vcpu_load_rebalancer_core uut (.*);

    always #5 i_clk = ~i_clk;

    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side: check, then decide ready for the next cycle
    initial begin : result_side
        int hold;
        t_placement got;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (i_out_ready && o_out_valid) begin
                got = '{o_unbalanced, o_vm_index, o_target_pcpu, o_moved, o_last_result};
                board.check_result(got);
            end
            // long enough to outlast a full batch sort and leave a result waiting
            if (hold_request && !hold_done) begin
                hold_done = 1;
                hold = 2000;
            end
            if (hold > 0) begin
                hold--;
                i_out_ready <= 0;
            end else if (items_sent > 60 && items_sent < 120) begin
                i_out_ready <= 1;
            end else begin
                hold = pick_gap();
                i_out_ready <= (hold == 0);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (i_out_ready && o_out_valid) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
            $display("vcpu_load_rebalancer_core_test: errors");
            $finish;
        end
    end

    task automatic send_vm(input bit [14:0] usage, input bit [4:0] cpu, input bit last,
                           input bit gaps);
        int gap;
        i_in_valid <= 1;
        i_vm_usage <= usage;
        i_current_pcpu <= cpu;
        i_last_vm <= last;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_vm(usage, cpu, last);
        items_sent++;
        gap = gaps ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (board.awaited.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [vlr_pkg::CFG_A_W-1:0] idx,
                             input logic [vlr_pkg::CFG_D_W-1:0] data);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == vlr_pkg::CFG_NUM_PCPUS)
            board.pcpus_reg = data[5:0];
        else
            board.threshold_reg = data[14:0];
        i_cfg_valid <= 0;
        @(posedge i_clk);
    endtask

    // one batch: skewed usages and shared homes make most batches unbalanced
    task automatic send_batch(input int n, input bit gaps);
        int i, style;
        bit [14:0] u;
        bit [4:0] c;
        style = $urandom_range(0, 3);
        for (i = 0; i < n; i++) begin
            case (style)
                0: u = $urandom_range(0, 32767);
                1: u = $urandom_range(0, 25600);
                2: u = 15'd100 * $urandom_range(0, 3);
                default: u = $urandom_range(0, 9) < 3 ? 15'd0 : 15'(32767 - $urandom_range(0, 15));
            endcase
            c = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                             : 5'($urandom_range(0, 3));
            send_vm(u, c, i == n - 1, gaps);
        end
    endtask

    initial begin : stimulus
        int n, k;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: lone vm with home out of range, all-idle balanced batch
        send_vm(15'h7fff, 5'd31, 1, 0);
        send_vm(15'd0, 5'd0, 0, 0);
        send_vm(15'd0, 5'd5, 1, 0);
        // equal usages sharing one home
        for (k = 0; k < 4; k++)
            send_vm(15'd5000, 5'd0, k == 3, 0);
        // more vms than cpus, least-load placement
        for (k = 0; k < 10; k++)
            send_vm(15'(k * 3000 + 7), 5'(k % 3), k == 9, 1);
        drain();
        write_reg(vlr_pkg::CFG_NUM_PCPUS, 15'd0);
        write_reg(vlr_pkg::CFG_THRESHOLD, 15'd0);
        send_vm(15'd1, 5'd31, 0, 0);
        send_vm(15'd2, 5'd0, 0, 0);
        send_vm(15'd25600, 5'd16, 1, 0);
        drain();

        while (items_sent < 470) begin
            case ($urandom_range(0, 6))
                0: write_reg(vlr_pkg::CFG_NUM_PCPUS, 15'd1);
                1: write_reg(vlr_pkg::CFG_NUM_PCPUS, 15'd32);
                2: write_reg(vlr_pkg::CFG_NUM_PCPUS, 15'($urandom_range(33, 63)));
                default: write_reg(vlr_pkg::CFG_NUM_PCPUS, 15'($urandom_range(2, 12)));
            endcase
            case ($urandom_range(0, 5))
                0: write_reg(vlr_pkg::CFG_THRESHOLD, 15'd0);
                1: write_reg(vlr_pkg::CFG_THRESHOLD, 15'd32767);
                2: write_reg(vlr_pkg::CFG_THRESHOLD, 15'd25600);
                default: write_reg(vlr_pkg::CFG_THRESHOLD, 15'($urandom_range(0, 3000)));
            endcase
            if (items_sent > 200 && !hold_request) begin
                // receiver stalls while a full batch and the next one are offered
                hold_request = 1;
                send_batch(32, 0);
                send_batch(6, 0);
            end
            for (k = $urandom_range(2, 5); k > 0; k--) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 36)
                                                : $urandom_range(1, 8);
                send_batch(n, $urandom_range(0, 3) != 0);
            end
            drain();
        end
        drain();
        repeat (200) @(posedge i_clk);

        $display("covered %0d vm items in %0d batches (%0d unbalanced), %0d results checked",
                 items_sent, board.batches, board.unbalanced_batches, board.results_seen);
        $display("pcpu counts 0 to 63 and thresholds 0 to 32767, with stalls on both sides");
        if (board.errors == 0 && board.awaited.size() == 0) begin
            $display("vcpu_load_rebalancer_core_test: clean");
        end else begin
            $display("%0d mismatches, %0d results never came", board.errors,
                     board.awaited.size());
            $display("vcpu_load_rebalancer_core_test: errors");
        end
        $finish;
    end
endmodule
